// File: sv/free_list_id_allocator_assert.svh
// Assertion macros for the free list ID allocator.
`ifndef FREE_LIST_ID_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_ID_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fla assertion failed");

// Next-cycle implication, checked out of reset.
`define FLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fla assertion failed");

`endif

// File: sv/fla_pkg.sv
// Shared types and constants for the free list ID allocator.
`default_nettype none

package fla_pkg;

    localparam int MAX_IDS_DEFAULT  = 128;
    localparam int RESET_ACTIVE_MAX = 128;
    localparam int CFG_W            = 8;
    localparam int CFG_MAX          = 255;
    localparam int RID_W            = 7;
    localparam int MODE_W           = 2;
    localparam int S_TDATA_W        = 8;
    localparam int M_TDATA_W        = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CHECK   = 2'd2
    } t_mode;

endpackage

`default_nettype wire

// File: sv/free_list_id_allocator.sv
// Top level of the free list ID allocator: request handling, pointers and allocation map.
//
//  channel   dir  handshake                 payload
//  request   in   i_s_tvalid / o_s_tready   tuser: mode, tdata: request_id
//  result    out  o_m_tvalid / i_m_tready   tdata: result_id, tuser: success
//  config    in   i_cfg_valid / o_cfg_ready i_cfg_data: active_ids
//
// One request per cycle; its result appears in the output register in the next cycle.
// The head ID is prefetched from the ring RAM each cycle, so back-to-back allocates
// run at full rate. Reset (i_rst_n low, synchronous) and every config write rebuild
// the ring through per-entry init marks; no clearing pass.
// Requests stall only while the output register holds an untaken result, or while
// a config write is offered.
`default_nettype none

module free_list_id_allocator #(
    parameter int MAX_IDS = fla_pkg::MAX_IDS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [fla_pkg::S_TDATA_W-1:0] i_s_tdata,  // [6:0] request_id
    input  wire logic [fla_pkg::MODE_W-1:0]    i_s_tuser,  // [1:0] mode
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic      [fla_pkg::M_TDATA_W-1:0] o_m_tdata,  // [6:0] result_id
    output logic                               o_m_tuser,  // [0] success
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fla_pkg::CFG_W-1:0]     i_cfg_data  // active_ids
);

    import fla_pkg::*;

    `include "free_list_id_allocator_assert.svh"

    localparam int CfgMax    = (MAX_IDS < CFG_MAX) ? MAX_IDS : CFG_MAX;
    localparam int RstActive = (MAX_IDS < RESET_ACTIVE_MAX) ? MAX_IDS : RESET_ACTIVE_MAX;
    localparam int IdW       = $clog2(CfgMax);
    localparam int CntW      = $clog2(CfgMax + 1);
    localparam int CmpW      = (CntW > RID_W) ? CntW : RID_W;

    logic [CntW-1:0]  r_active, n_active;
    logic [IdW-1:0]   r_head, n_head;
    logic [IdW-1:0]   r_tail, n_tail;
    logic [CntW-1:0]  r_count, n_count;
    logic [CfgMax-1:0] r_alloc;
    logic             r_out_valid;
    logic [RID_W-1:0] r_out_id, n_out_id;
    logic             r_out_ok, n_out_ok;

    logic             accept;
    logic             cfg_we;
    t_mode            mode;
    logic [RID_W-1:0] rid;
    logic [IdW-1:0]   rid_idx;
    logic             rid_in_range;
    logic [IdW-1:0]   head_id;
    logic             ring_wr;
    logic             alloc_set;
    logic             alloc_clr;
    logic [CFG_W-1:0] cfg_nz;
    logic [CntW-1:0]  cfg_active;

    function automatic logic [IdW-1:0] ring_next(input logic [IdW-1:0] p,
                                                 input logic [CntW-1:0] act);
        logic [IdW:0] nx;
        nx = {1'b0, p} + 1'b1;
        return (nx >= (IdW+1)'(act)) ? '0 : nx[IdW-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_s_tready  = (!r_out_valid || i_m_tready) && !i_cfg_valid;
    assign accept      = i_s_tvalid && o_s_tready;

    assign mode         = t_mode'(i_s_tuser);
    assign rid          = i_s_tdata[RID_W-1:0];
    assign rid_idx      = IdW'(rid);
    assign rid_in_range = CmpW'(rid) < CmpW'(r_active);

    // clamp the written count to 1..CfgMax
    assign cfg_nz     = (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;
    assign cfg_active = (int'(cfg_nz) > CfgMax) ? CntW'(CfgMax) : CntW'(cfg_nz);

    always_comb begin
        n_active  = r_active;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_out_id  = rid;
        n_out_ok  = 1'b0;
        ring_wr   = 1'b0;
        alloc_set = 1'b0;
        alloc_clr = 1'b0;
        if (cfg_we) begin
            n_active = cfg_active;
            n_head   = '0;
            n_tail   = IdW'(cfg_active - 1'b1);
            n_count  = cfg_active;
        end else if (accept) begin
            case (mode)
                MODE_ALLOC: begin
                    n_out_id = '0;
                    if (r_count != '0) begin
                        alloc_set = 1'b1;
                        n_head    = ring_next(r_head, r_active);
                        n_count   = r_count - 1'b1;
                        n_out_id  = RID_W'(head_id);
                        n_out_ok  = 1'b1;
                    end
                end
                MODE_RELEASE: begin
                    if (rid_in_range && r_alloc[rid_idx]) begin
                        alloc_clr = 1'b1;
                        ring_wr   = 1'b1;
                        n_tail    = ring_next(r_tail, r_active);
                        n_count   = r_count + 1'b1;
                        n_out_ok  = 1'b1;
                    end
                end
                MODE_CHECK: begin
                    n_out_ok = rid_in_range && !r_alloc[rid_idx];
                end
                default: begin
                    n_out_ok = 1'b0;
                end
            endcase
        end
    end

    fla_ring #(
        .DEPTH (CfgMax),
        .IDW   (IdW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_we),
        .i_wr_en   (ring_wr),
        .i_wr_addr (n_tail),
        .i_wr_data (rid_idx),
        .i_rd_addr (n_head),
        .o_rd_data (head_id)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= CntW'(RstActive);
            r_head      <= '0;
            r_tail      <= IdW'(RstActive - 1);
            r_count     <= CntW'(RstActive);
            r_alloc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            if (cfg_we) begin
                r_alloc <= '0;
            end else begin
                if (alloc_set) begin
                    r_alloc[head_id] <= 1'b1;
                end
                if (alloc_clr) begin
                    r_alloc[rid_idx] <= 1'b0;
                end
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_id <= n_out_id;
            r_out_ok <= n_out_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_id);
    assign o_m_tuser  = r_out_ok;

    `FLA_ASSERT_NOW(a_count_le_active, i_clk, i_rst_n, 1'b1, r_count <= r_active)
    `FLA_ASSERT_NEXT(a_cfg_rebuild, i_clk, i_rst_n, cfg_we,
        (r_count == r_active) && (r_head == '0) && (r_alloc == '0))
    `FLA_ASSERT_NEXT(a_alloc_pop, i_clk, i_rst_n,
        accept && (mode == MODE_ALLOC) && (r_count != '0),
        (r_count == $past(r_count) - 1'b1) && r_out_ok && r_alloc[$past(head_id)])
    `FLA_ASSERT_NEXT(a_alloc_empty, i_clk, i_rst_n,
        accept && (mode == MODE_ALLOC) && (r_count == '0),
        !r_out_ok && (r_out_id == '0) && (r_count == '0))

endmodule

`default_nettype wire

// File: sv/fla_ring.sv
// Free ID ring memory with registered read, write bypass and per-entry init marks.
`default_nettype none

module fla_ring #(
    parameter int DEPTH = 128,
    parameter int IDW   = 7
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_clear,
    input  wire logic           i_wr_en,
    input  wire logic [IDW-1:0] i_wr_addr,
    input  wire logic [IDW-1:0] i_wr_data,
    input  wire logic [IDW-1:0] i_rd_addr,
    output logic      [IDW-1:0] o_rd_data
);

    logic [IDW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [IDW-1:0] r_rd_data;
    logic [IDW-1:0] r_rd_addr;
    logic [IDW-1:0] r_byp_data;
    logic           r_byp;
    logic           r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_byp_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_byp     <= 1'b0;
            r_rd_init <= 1'b1;
            r_rd_addr <= '0;
        end else begin
            r_rd_addr <= i_rd_addr;
            if (i_clear) begin
                r_valid   <= '0;
                r_byp     <= 1'b0;
                r_rd_init <= 1'b1;
            end else begin
                if (i_wr_en) begin
                    r_valid[i_wr_addr] <= 1'b1;
                end
                // a write to the address being read wins over the old word
                r_byp     <= i_wr_en && (i_wr_addr == i_rd_addr);
                r_rd_init <= !r_valid[i_rd_addr];
            end
        end
    end

    // untouched entries still hold their own index
    assign o_rd_data = r_byp ? r_byp_data : (r_rd_init ? r_rd_addr : r_rd_data);

endmodule

`default_nettype wire

// File: verif/tb_free_list_id_allocator.sv
// Self-checking testbench for the free list ID allocator: directed and random requests.
`default_nettype none

module tb_free_list_id_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import fla_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;  // undefined request kind
    localparam int                POOL_MAX    = 128;
    localparam int                STALL_LIMIT = 2000;

    typedef struct packed {
        logic [RID_W-1:0] id;
        logic             ok;
    } t_outcome;

    // Tracks the free ring and the allocation map; predicts one outcome per request.
    class alloc_scoreboard;
        logic [CFG_W-1:0] active_ids;
        logic [RID_W-1:0] ring[POOL_MAX];
        logic             held[POOL_MAX];
        logic [RID_W-1:0] head;
        logic [RID_W-1:0] tail;
        logic [CFG_W-1:0] free_count;
        t_outcome         awaited[$];
        int               mismatches;

        function new();
            mismatches = 0;
            active_ids = CFG_W'(POOL_MAX);
            rebuild();
        endfunction

        function void rebuild();
            for (int i = 0; i < POOL_MAX; i++) begin
                ring[i] = RID_W'(i);
                held[i] = 1'b0;
            end
            head       = '0;
            tail       = RID_W'(active_ids - 1);
            free_count = active_ids;
        endfunction

        function void set_active_ids(logic [CFG_W-1:0] value);
            if (value == 0)
                active_ids = CFG_W'(1);
            else if (value > POOL_MAX)
                active_ids = CFG_W'(POOL_MAX);
            else
                active_ids = value;
            rebuild();
        endfunction

        function logic [RID_W-1:0] ring_advance(logic [RID_W-1:0] p);
            logic [CFG_W-1:0] n;
            n = {1'b0, p} + 1'b1;
            return (n >= active_ids) ? '0 : n[RID_W-1:0];
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [RID_W-1:0] rid);
            t_outcome o;
            o.id = rid;
            o.ok = 1'b0;
            case (mode)
                MODE_ALLOC: begin
                    o.id = '0;
                    if (free_count != 0) begin
                        o.id = ring[head];
                        o.ok = 1'b1;
                        held[o.id] = 1'b1;
                        head = ring_advance(head);
                        free_count--;
                    end
                end
                MODE_RELEASE: begin
                    if (rid < active_ids && held[rid]) begin
                        held[rid] = 1'b0;
                        tail = ring_advance(tail);
                        ring[tail] = rid;
                        free_count++;
                        o.ok = 1'b1;
                    end
                end
                MODE_CHECK: begin
                    o.ok = (rid < active_ids) && !held[rid];
                end
                default: ;
            endcase
            awaited.push_back(o);
        endfunction

        function void check_result(logic [RID_W-1:0] id, logic ok);
            t_outcome exp_o;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result: id %0d success %0b", $realtime, id, ok);
                mismatches++;
                return;
            end
            exp_o = awaited.pop_front();
            if (exp_o.id !== id) begin
                $display("%0t: result_id mismatch: expected %0d, actual %0d",
                         $realtime, exp_o.id, id);
                mismatches++;
            end
            if (exp_o.ok !== ok) begin
                $display("%0t: success mismatch: expected %0b, actual %0b",
                         $realtime, exp_o.ok, ok);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Return a random allocated ID, or -1 when none is held.
        function int pick_held_id();
            int ids[$];
            for (int i = 0; i < POOL_MAX; i++)
                if (held[i])
                    ids.push_back(i);
            if (ids.size() == 0)
                return -1;
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;  // [6:0] request_id
    logic [MODE_W-1:0]    i_s_tuser;  // [1:0] mode
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;  // [6:0] result_id
    logic                 o_m_tuser;  // [0] success
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data;

    alloc_scoreboard sb;
    int              stall_pct;
    int              quiet_cycles;

    free_list_id_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // start low so the first rising edge already sees reset
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Score every handshake and watch for a hung block.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata[RID_W-1:0], o_m_tuser);
            if (i_s_tvalid && o_s_tready)
                sb.note_request(i_s_tuser, i_s_tdata[RID_W-1:0]);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_active_ids(i_cfg_data);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic issue(input logic [MODE_W-1:0] mode, input logic [RID_W-1:0] rid);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {1'b0, rid};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    // let the monitor score the last accepted item before counting what is left
    task automatic drain();
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write active_ids with the request side idle and every result collected.
    task automatic write_active_ids(input logic [CFG_W-1:0] value);
        i_s_tvalid <= 1'b0;
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic stream_requests(input int count, input int alloc_pct);
        int               sent;
        int               burst;
        int               gap;
        int               roll;
        int               pick;
        logic [MODE_W-1:0] mode;
        logic [RID_W-1:0]  rid;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < count; k++) begin
                roll = $urandom_range(0, 99);
                rid  = RID_W'($urandom_range(0, POOL_MAX - 1));
                if (roll < alloc_pct) begin
                    mode = MODE_ALLOC;
                end else if (roll < alloc_pct + (100 - alloc_pct) / 2) begin
                    mode = MODE_RELEASE;
                    pick = sb.pick_held_id();
                    // favor IDs that are really out, so the ring keeps turning
                    if (pick >= 0 && $urandom_range(0, 9) != 0)
                        rid = RID_W'(pick);
                end else if (roll < 96) begin
                    mode = MODE_CHECK;
                    if ($urandom_range(0, 1) == 0)
                        rid = RID_W'($urandom_range(0, sb.active_ids - 1));
                end else begin
                    mode = MODE_SPARE;
                end
                issue(mode, rid);
                sent++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] value, input int count,
                             input int alloc_pct, input int stall);
        write_active_ids(value);
        stall_pct = stall;
        stream_requests(count, alloc_pct);
    endtask

    initial begin
        sb           = new();
        stall_pct    = 0;
        quiet_cycles = 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= MODE_ALLOC;
        i_m_tready  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset state: all 128 IDs free.
        issue(MODE_CHECK, 7'd127);
        issue(MODE_CHECK, 7'd0);
        issue(MODE_RELEASE, 7'd0);
        issue(MODE_SPARE, 7'd127);
        issue(MODE_ALLOC, 7'd127);
        issue(MODE_RELEASE, 7'd0);

        // Zero is taken as a single ID.
        write_active_ids(8'd0);
        issue(MODE_ALLOC, 7'd0);
        issue(MODE_ALLOC, 7'd0);
        issue(MODE_CHECK, 7'd0);
        issue(MODE_RELEASE, 7'd1);
        issue(MODE_RELEASE, 7'd0);
        issue(MODE_ALLOC, 7'd85);

        write_active_ids(8'd2);
        issue(MODE_ALLOC, 7'd0);
        issue(MODE_ALLOC, 7'd0);
        issue(MODE_ALLOC, 7'd0);
        issue(MODE_RELEASE, 7'd1);
        issue(MODE_RELEASE, 7'd1);
        issue(MODE_RELEASE, 7'd0);
        issue(MODE_ALLOC, 7'd42);
        issue(MODE_CHECK, 7'd127);
        issue(MODE_RELEASE, 7'd127);
        issue(MODE_CHECK, 7'd1);
        issue(MODE_SPARE, 7'd0);
        issue(MODE_ALLOC, 7'd0);

        run_phase(8'd1,   100, 45, 0);
        run_phase(8'd3,   150, 50, 30);
        run_phase(8'd128, 300, 80, 0);
        run_phase(8'd7,   150, 45, 60);
        run_phase(8'd0,    60, 40, 20);
        run_phase(8'd129, 150, 55, 30);
        run_phase(8'd16,  150, 60, 0);
        run_phase(8'd255, 300, 85, 40);
        run_phase(CFG_W'($urandom_range(1, 128)), 150, 50, 60);
        run_phase(8'd2,   120, 45, 10);
        run_phase(CFG_W'($urandom_range(0, 255)), 150, 55, 0);

        drain();
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: free_list_id_allocator.f
+incdir+sv
sv/fla_pkg.sv
sv/fla_ring.sv
sv/free_list_id_allocator.sv
verif/tb_free_list_id_allocator.sv
